@@ hdl/plsc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plsc_pkg: shared constants and unit interface types
// Sizes of the sample store, fixed-point format and the request/response
// structs of the shared multiplier and divider.
// ----------------------------------------------------------------------------
package plsc_pkg;

	localparam int MAX_SAMPLES = 1024;
	localparam int FRAC_BITS   = 16;
	localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
	localparam int ADDR_W      = $clog2(MAX_SAMPLES);
	localparam int DATA_W      = 64;
	localparam int HALF_W      = DATA_W / 2;
	localparam int SAMPLE_W    = 16;
	localparam int DIFF_W      = SAMPLE_W + 1;
	localparam int PEN_W       = 47;
	localparam int COST_W      = DATA_W - 1;
	localparam int CFG_IDX_W   = 1;

	localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	localparam logic [CFG_IDX_W-1:0] REG_PENALTY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SEG = 1'b1;

	typedef struct packed {
		logic                     start;
		logic signed [DATA_W-1:0] a;
		logic signed [DATA_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [DATA_W-1:0] p;
	} mul_rsp_t;

	typedef struct packed {
		logic                     start;
		logic signed [DATA_W-1:0] num;
		logic [CNT_W-1:0]         den;
	} div_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [DATA_W-1:0] quo;
	} div_rsp_t;

endpackage

`default_nettype wire

@@ hdl/plsc_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plsc_ram: generic simple dual-port memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module plsc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ hdl/plsc_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plsc_mul: shared saturating multiplier
// Signed 64 x 64 product clamped to the signed 64-bit range, built from
// 32 x 32 partial products taken one at a time.
// ----------------------------------------------------------------------------
module plsc_mul import plsc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	localparam int ACC_W = DATA_W + HALF_W + 1;

	localparam logic [2:0] MC_IDLE = 3'd0;
	localparam logic [2:0] MC_LL   = 3'd1;
	localparam logic [2:0] MC_HL   = 3'd2;
	localparam logic [2:0] MC_LH   = 3'd3;
	localparam logic [2:0] MC_LAST = 3'd4;

	logic [2:0]        cnt_q;
	logic              done_q;
	logic              neg_q;
	logic [DATA_W-1:0] ua_q;
	logic [DATA_W-1:0] ub_q;
	logic [DATA_W-1:0] pp_q;
	logic [ACC_W-1:0]  acc_q;
	logic [HALF_W-1:0] ma;
	logic [HALF_W-1:0] mb;
	logic [DATA_W-1:0] pp;
	logic [DATA_W-1:0] a_mag;
	logic [DATA_W-1:0] b_mag;
	logic              ovf;
	logic [ACC_W-1:0]  pp_hi;

	assign a_mag = req.a[DATA_W-1] ? (DATA_W'(0) - DATA_W'(req.a)) : DATA_W'(req.a);
	assign b_mag = req.b[DATA_W-1] ? (DATA_W'(0) - DATA_W'(req.b)) : DATA_W'(req.b);

	always_comb begin
		case (cnt_q)
			MC_LL: begin
				ma = ua_q[HALF_W-1:0];
				mb = ub_q[HALF_W-1:0];
			end
			MC_HL: begin
				ma = ua_q[DATA_W-1:HALF_W];
				mb = ub_q[HALF_W-1:0];
			end
			default: begin
				ma = ua_q[HALF_W-1:0];
				mb = ub_q[DATA_W-1:HALF_W];
			end
		endcase
	end

	assign pp    = DATA_W'(ma) * DATA_W'(mb);
	assign pp_hi = {{(ACC_W-DATA_W-HALF_W){1'b0}}, pp_q, {HALF_W{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= MC_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (cnt_q)
				MC_IDLE: begin
					if (req.start) begin
						cnt_q <= MC_LL;
					end
				end
				MC_LL:   cnt_q <= MC_HL;
				MC_HL:   cnt_q <= MC_LH;
				MC_LH:   cnt_q <= MC_LAST;
				MC_LAST: begin
					cnt_q  <= MC_IDLE;
					done_q <= 1'b1;
				end
				default: cnt_q <= MC_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cnt_q)
			MC_IDLE: begin
				if (req.start) begin
					ua_q  <= a_mag;
					ub_q  <= b_mag;
					neg_q <= req.a[DATA_W-1] ^ req.b[DATA_W-1];
				end
			end
			MC_LL: pp_q <= pp;
			MC_HL: begin
				acc_q <= ACC_W'(pp_q);
				pp_q  <= pp;
			end
			MC_LH: begin
				acc_q <= acc_q + pp_hi;
				pp_q  <= pp;
			end
			MC_LAST: acc_q <= acc_q + pp_hi;
			default: ;
		endcase
	end

	// both high halves set means the product is at least 2^64
	assign ovf = ((|ua_q[DATA_W-1:HALF_W]) && (|ub_q[DATA_W-1:HALF_W]))
		|| (|acc_q[ACC_W-1:DATA_W-1]);

	always_comb begin
		rsp.done = done_q;
		if (ovf) begin
			rsp.p = neg_q ? SAT_MIN : SAT_MAX;
		end else if (neg_q) begin
			rsp.p = DATA_W'(0) - acc_q[DATA_W-1:0];
		end else begin
			rsp.p = acc_q[DATA_W-1:0];
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) req.start |-> cnt_q == MC_IDLE)
		else $error("multiplier started while busy");
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> $past(cnt_q == MC_LAST))
		else $error("multiplier done out of sequence");

endmodule

`default_nettype wire

@@ hdl/plsc_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plsc_div: shared rounding divider
// Signed 64-bit numerator over a small positive divisor, one quotient bit
// per cycle, then rounding to nearest with ties away from zero.
// ----------------------------------------------------------------------------
module plsc_div import plsc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int STEP_W = $clog2(DATA_W + 2);
	localparam logic [STEP_W-1:0] DV_IDLE  = STEP_W'(0);
	localparam logic [STEP_W-1:0] DV_ROUND = STEP_W'(DATA_W + 1);

	logic [STEP_W-1:0] cnt_q;
	logic              done_q;
	logic              neg_q;
	logic [DATA_W-1:0] quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  den_q;
	logic [CNT_W:0]    rem_sh;
	logic              ge;
	logic [CNT_W:0]    rem_dbl;

	assign rem_sh  = {rem_q, quo_q[DATA_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_dbl = {rem_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= DV_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cnt_q == DV_IDLE) begin
				if (req.start) begin
					cnt_q <= STEP_W'(1);
				end
			end else if (cnt_q == DV_ROUND) begin
				cnt_q  <= DV_IDLE;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_q == DV_IDLE) begin
			if (req.start) begin
				quo_q <= req.num[DATA_W-1] ? (DATA_W'(0) - DATA_W'(req.num)) : DATA_W'(req.num);
				neg_q <= req.num[DATA_W-1];
				den_q <= req.den;
				rem_q <= '0;
			end
		end else if (cnt_q == DV_ROUND) begin
			if (rem_dbl >= {1'b0, den_q}) begin
				quo_q <= quo_q + DATA_W'(1);
			end
		end else begin
			rem_q <= ge ? CNT_W'(rem_sh - {1'b0, den_q}) : CNT_W'(rem_sh);
			quo_q <= {quo_q[DATA_W-2:0], ge};
		end
	end

	always_comb begin
		rsp.done = done_q;
		rsp.quo  = neg_q ? (DATA_W'(0) - quo_q) : quo_q;
	end

	assert property (@(posedge clk) disable iff (!arst_n) req.start |-> cnt_q == DV_IDLE)
		else $error("divider started while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != DV_IDLE && cnt_q != STEP_W'(1)) |-> rem_q < den_q)
		else $error("divider remainder out of range");

endmodule

`default_nettype wire

@@ hdl/pelt_linear_spline_changepoint.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pelt_linear_spline_changepoint: online linear-spline change-point search
// Each sample updates the spline cost of every live segment start, picks the
// cheapest penalised start and prunes dominated starts from the front.
// ----------------------------------------------------------------------------
// Usage
//  item channel (item_valid/item_ready): sample and series_start. An item
//   with series_start set clears the series and becomes its first sample.
//  result channel (result_valid/result_ready): end_index, best_start and
//   best_cost, one result for each sample from the second of a series on.
//   The first sample and a sample into a full series give no result.
//  config port (cfg_we/cfg_index/cfg_data): penalty (index 0) and min_segment
//   (index 1), written by the user only while no item is in flight, unchecked.
//  One item at a time: item_ready is high only while the sequencer is idle.
//  Work per item: for each live start the cost pass runs ten products on the
//   shared multiplier and three quotients on the shared divider; then comes
//   a selection step per candidate start and a prune check per pruned start.
//   The shared divider dominates.
//  The result register holds while result_ready is low; the next item is
//   still accepted and the block waits only when that item's result is due.
//  Reset clears the series, penalty to 0 and min_segment to 2; no memory
//   clearing pass is needed, so items are taken right after reset.
// ----------------------------------------------------------------------------
module pelt_linear_spline_changepoint import plsc_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_ready,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       series_start,
	output logic                       result_valid,
	input  logic                       result_ready,
	output logic [CNT_W-1:0]           end_index,
	output logic [ADDR_W-1:0]          best_start,
	output logic [COST_W-1:0]          best_cost,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [PEN_W-1:0]           cfg_data
);

	localparam int HI_W = CNT_W + 2;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_L1CHK  = 4'd1;
	localparam logic [3:0] S_L1RD   = 4'd2;
	localparam logic [3:0] S_L1LD   = 4'd3;
	localparam logic [3:0] S_L1OP   = 4'd4;
	localparam logic [3:0] S_L2INIT = 4'd5;
	localparam logic [3:0] S_L2RD   = 4'd6;
	localparam logic [3:0] S_L2SUM  = 4'd7;
	localparam logic [3:0] S_L2SEL  = 4'd8;
	localparam logic [3:0] S_OPTWR  = 4'd9;
	localparam logic [3:0] S_PCHK   = 4'd10;
	localparam logic [3:0] S_PCMP   = 4'd11;
	localparam logic [3:0] S_OUT    = 4'd12;

	localparam logic [3:0] ST_LEND  = 4'd0;
	localparam logic [3:0] ST_ACUR  = 4'd1;
	localparam logic [3:0] ST_APREV = 4'd2;
	localparam logic [3:0] ST_DD    = 4'd3;
	localparam logic [3:0] ST_B1    = 4'd4;
	localparam logic [3:0] ST_B2    = 4'd5;
	localparam logic [3:0] ST_T1    = 4'd6;
	localparam logic [3:0] ST_T2    = 4'd7;
	localparam logic [3:0] ST_T3    = 4'd8;
	localparam logic [3:0] ST_U1    = 4'd9;
	localparam logic [3:0] ST_U2    = 4'd10;
	localparam logic [3:0] ST_V1    = 4'd11;
	localparam logic [3:0] ST_V2    = 4'd12;

	function automatic logic signed [DATA_W-1:0] sat_add(
		input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b
	);
		logic signed [DATA_W-1:0] s;
		s = a + b;
		if (a[DATA_W-1] == b[DATA_W-1] && s[DATA_W-1] != a[DATA_W-1]) begin
			return a[DATA_W-1] ? SAT_MIN : SAT_MAX;
		end
		return s;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat_neg(input logic signed [DATA_W-1:0] a);
		return (a == SAT_MIN) ? SAT_MAX : -a;
	endfunction

	// control
	logic [3:0]       state_q;
	logic [3:0]       step_q;
	logic             busy_q;
	logic             first_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] fls_q;
	logic [CNT_W-1:0] s_q;
	logic [PEN_W-1:0] penalty_q;
	logic [CNT_W-1:0] min_seg_q;
	logic             out_valid_q;

	// datapath
	logic signed [SAMPLE_W-1:0] last_sample_q;
	logic signed [SAMPLE_W-1:0] yl_q;
	logic signed [SAMPLE_W-1:0] yb_q;
	logic signed [DIFF_W-1:0]   d_q;
	logic signed [DIFF_W-1:0]   e_q;
	logic [CNT_W-1:0]           len_q;
	logic signed [DATA_W-1:0]   sum_s_q;
	logic signed [DATA_W-1:0]   c_q;
	logic signed [DATA_W-1:0]   acur_q;
	logic signed [DATA_W-1:0]   aprev_q;
	logic signed [DATA_W-1:0]   tmp_q;
	logic signed [DATA_W-1:0]   seg0_q;
	logic signed [DATA_W-1:0]   sum_q;
	logic signed [DATA_W-1:0]   best_q;
	logic [ADDR_W-1:0]          best_s_q;
	logic [CNT_W-1:0]           end_index_q;
	logic [ADDR_W-1:0]          best_start_q;
	logic [COST_W-1:0]          best_cost_q;

	// unit links
	mul_req_t mul_req;
	mul_rsp_t mul_rsp;
	div_req_t div_req;
	div_rsp_t div_rsp;

	// memories
	logic [SAMPLE_W-1:0] hist_rdata;
	logic                slope_we;
	logic [ADDR_W-1:0]   slope_waddr;
	logic [DATA_W-1:0]   slope_wdata;
	logic [DATA_W-1:0]   slope_rdata;
	logic                seg_we;
	logic [DATA_W-1:0]   seg_rdata;
	logic                opt_we;
	logic [DATA_W-1:0]   opt_rdata;
	logic                prune_we;
	logic [DATA_W-1:0]   prune_rdata;

	logic                       accept;
	logic [CNT_W-1:0]           cnt_eff;
	logic                       full;
	logic                       hist_we;
	logic                       step_is_div;
	logic                       op_done;
	logic signed [DATA_W-1:0]   slope_new;
	logic signed [DATA_W-1:0]   seg_new;
	logic signed [DIFF_W-1:0]   first_diff;
	logic [CNT_W-1:0]           ms_eff;
	logic [CNT_W-1:0]           lo;
	logic signed [HI_W-1:0]     hi;
	logic [CNT_W-1:0]           s_next;
	logic signed [DATA_W-1:0]   opt_val;
	logic signed [DATA_W-1:0]   seg_val;
	logic signed [DATA_W-1:0]   sum_pen;
	logic signed [DATA_W-1:0]   len64;
	logic signed [DATA_W-1:0]   d64;
	logic signed [DATA_W-1:0]   e64;

	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_valid && item_ready;
	assign cnt_eff    = series_start ? '0 : cnt_q;
	assign full       = cnt_eff >= CNT_W'(MAX_SAMPLES);
	assign hist_we    = accept && !full;
	assign first_diff = DIFF_W'(sample) - DIFF_W'(last_sample_q);

	assign ms_eff = (min_seg_q == '0) ? CNT_W'(1) : min_seg_q;
	assign lo     = (fls_q > CNT_W'(1)) ? fls_q : CNT_W'(1);
	// one past the last candidate start
	assign hi     = $signed({2'b00, cnt_q}) - $signed({2'b00, ms_eff}) + HI_W'(1);
	assign s_next = s_q + CNT_W'(1);

	assign step_is_div = (step_q == ST_ACUR) || (step_q == ST_APREV) || (step_q == ST_T3);
	assign op_done     = busy_q && (mul_rsp.done || div_rsp.done);

	assign len64 = DATA_W'(len_q);
	assign d64   = DATA_W'(d_q);
	assign e64   = DATA_W'(e_q);

	always_comb begin
		mul_req.start = (state_q == S_L1OP) && !busy_q && !step_is_div;
		div_req.start = (state_q == S_L1OP) && !busy_q && step_is_div;
		mul_req.a     = '0;
		mul_req.b     = '0;
		div_req.num   = '0;
		div_req.den   = CNT_W'(1);
		case (step_q)
			ST_LEND: begin
				mul_req.a = len64;
				mul_req.b = d64;
			end
			ST_ACUR: begin
				div_req.num = d64 <<< FRAC_BITS;
				div_req.den = len_q;
			end
			ST_APREV: begin
				div_req.num = e64 <<< FRAC_BITS;
				div_req.den = len_q - CNT_W'(1);
			end
			ST_DD: begin
				mul_req.a = d64;
				mul_req.b = d64;
			end
			ST_B1: begin
				mul_req.a = len64 - DATA_W'(1);
				mul_req.b = d64;
			end
			ST_B2: begin
				mul_req.a = len64;
				mul_req.b = e64;
			end
			ST_T1: begin
				mul_req.a = sat_add(aprev_q, acur_q);
				mul_req.b = tmp_q;
			end
			ST_T2: begin
				mul_req.a = tmp_q;
				mul_req.b = (len64 <<< 1) - DATA_W'(1);
			end
			ST_T3: begin
				div_req.num = tmp_q;
				div_req.den = CNT_W'(6);
			end
			ST_U1: begin
				mul_req.a = sat_add(acur_q, -aprev_q);
				mul_req.b = DATA_W'(2);
			end
			ST_U2: begin
				mul_req.a = tmp_q;
				mul_req.b = sum_s_q;
			end
			ST_V1: begin
				mul_req.a = aprev_q;
				mul_req.b = len64 <<< 1;
			end
			ST_V2: begin
				mul_req.a = tmp_q;
				mul_req.b = d64;
			end
			default: ;
		endcase
	end

	plsc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	plsc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign slope_new = sat_add(sum_s_q, mul_rsp.p);
	assign seg_new   = sat_add(c_q, sat_neg(mul_rsp.p));

	always_comb begin
		slope_we    = 1'b0;
		slope_waddr = s_q[ADDR_W-1:0];
		slope_wdata = slope_new;
		if (state_q == S_IDLE) begin
			slope_we    = hist_we && (cnt_eff != '0);
			slope_waddr = cnt_eff[ADDR_W-1:0];
			slope_wdata = DATA_W'(first_diff);
		end else if (state_q == S_L1OP && op_done && step_q == ST_LEND) begin
			slope_we = 1'b1;
		end
	end

	assign seg_we   = (state_q == S_L1OP) && op_done && (step_q == ST_V2);
	assign opt_we   = (state_q == S_OPTWR);
	assign prune_we = (state_q == S_L2SUM);

	// entries beyond what this series has written read as zero
	assign opt_val = (s_q < CNT_W'(2)) ? '0 : $signed(opt_rdata);
	assign seg_val = (s_q == cnt_q - CNT_W'(1)) ? '0 :
		(s_q == '0) ? seg0_q : $signed(seg_rdata);
	assign sum_pen = sat_add(sum_q, DATA_W'(penalty_q));

	plsc_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SAMPLES)) u_hist (
		.clk   (clk),
		.we    (hist_we),
		.waddr (cnt_eff[ADDR_W-1:0]),
		.wdata (sample),
		.raddr (ADDR_W'(s_q - CNT_W'(1))),
		.rdata (hist_rdata)
	);

	plsc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SAMPLES)) u_slope (
		.clk   (clk),
		.we    (slope_we),
		.waddr (slope_waddr),
		.wdata (slope_wdata),
		.raddr (s_q[ADDR_W-1:0]),
		.rdata (slope_rdata)
	);

	plsc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SAMPLES)) u_seg (
		.clk   (clk),
		.we    (seg_we),
		.waddr (s_q[ADDR_W-1:0]),
		.wdata (seg_new),
		.raddr (s_q[ADDR_W-1:0]),
		.rdata (seg_rdata)
	);

	plsc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SAMPLES + 1)) u_opt (
		.clk   (clk),
		.we    (opt_we),
		.waddr (cnt_q),
		.wdata (best_q),
		.raddr (s_q),
		.rdata (opt_rdata)
	);

	plsc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SAMPLES)) u_prune (
		.clk   (clk),
		.we    (prune_we),
		.waddr (s_q[ADDR_W-1:0]),
		.wdata (sat_add(opt_val, seg_val)),
		.raddr (fls_q[ADDR_W-1:0]),
		.rdata (prune_rdata)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= ST_LEND;
			busy_q      <= 1'b0;
			first_q     <= 1'b0;
			cnt_q       <= '0;
			fls_q       <= '0;
			s_q         <= '0;
			seg0_q      <= '0;
			penalty_q   <= '0;
			min_seg_q   <= CNT_W'(2);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PENALTY: penalty_q <= cfg_data;
					REG_MIN_SEG: min_seg_q <= cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
			if (out_valid_q && result_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (series_start) begin
							fls_q  <= '0;
							seg0_q <= '0;
						end
						if (!full) begin
							cnt_q <= cnt_eff + CNT_W'(1);
							s_q   <= cnt_eff - CNT_W'(1);
							if (cnt_eff != '0) begin
								state_q <= S_L1CHK;
							end
						end
					end
				end
				S_L1CHK: state_q <= (s_q >= lo) ? S_L1RD : S_L2INIT;
				S_L1RD:  state_q <= S_L1LD;
				S_L1LD: begin
					step_q  <= ST_LEND;
					busy_q  <= 1'b0;
					state_q <= S_L1OP;
				end
				S_L1OP: begin
					if (!busy_q) begin
						busy_q <= 1'b1;
					end else if (op_done) begin
						busy_q <= 1'b0;
						step_q <= step_q + 4'd1;
						if (step_q == ST_V2) begin
							if (s_q == CNT_W'(1)) begin
								seg0_q <= seg_new;
							end
							s_q     <= s_q - CNT_W'(1);
							state_q <= S_L1CHK;
						end
					end
				end
				S_L2INIT: begin
					s_q     <= fls_q;
					first_q <= 1'b1;
					state_q <= S_L2RD;
				end
				S_L2RD:  state_q <= S_L2SUM;
				S_L2SUM: state_q <= S_L2SEL;
				S_L2SEL: begin
					first_q <= 1'b0;
					if ($signed({2'b00, s_next}) < hi) begin
						s_q     <= s_next;
						state_q <= S_L2RD;
					end else begin
						state_q <= S_OPTWR;
					end
				end
				S_OPTWR: state_q <= S_PCHK;
				S_PCHK:  state_q <= ($signed({2'b00, fls_q}) < hi) ? S_PCMP : S_OUT;
				S_PCMP: begin
					if ($signed(prune_rdata) >= best_q) begin
						fls_q   <= fls_q + CNT_W'(1);
						state_q <= S_PCHK;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || result_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (hist_we) begin
					last_sample_q <= sample;
					yl_q          <= sample;
					yb_q          <= last_sample_q;
				end
			end
			S_L1RD: len_q <= cnt_q - s_q;
			S_L1LD: begin
				d_q     <= DIFF_W'(yl_q) - DIFF_W'($signed(hist_rdata));
				e_q     <= DIFF_W'(yb_q) - DIFF_W'($signed(hist_rdata));
				sum_s_q <= $signed(slope_rdata);
				c_q     <= (s_q == cnt_q - CNT_W'(2)) ? '0 : $signed(seg_rdata);
			end
			S_L1OP: begin
				if (op_done) begin
					case (step_q)
						ST_LEND:  sum_s_q <= slope_new;
						ST_ACUR:  acur_q  <= div_rsp.quo;
						ST_APREV: aprev_q <= div_rsp.quo;
						ST_DD:    c_q     <= sat_add(c_q, mul_rsp.p <<< (FRAC_BITS + 1));
						ST_B2:    tmp_q   <= tmp_q - mul_rsp.p;
						ST_T3:    c_q     <= sat_add(c_q, div_rsp.quo);
						ST_U2:    c_q     <= seg_new;
						ST_V2:    c_q     <= seg_new;
						default:  tmp_q   <= mul_rsp.p;
					endcase
				end
			end
			S_L2SUM: sum_q <= sat_add(opt_val, seg_val);
			S_L2SEL: begin
				if (first_q || best_q > sum_pen) begin
					best_q   <= sum_pen;
					best_s_q <= s_q[ADDR_W-1:0];
				end
			end
			S_OUT: begin
				if (!out_valid_q || result_ready) begin
					end_index_q  <= cnt_q;
					best_start_q <= best_s_q;
					best_cost_q  <= best_q[DATA_W-1] ? '0 : best_q[COST_W-1:0];
				end
			end
			default: ;
		endcase
	end

	assign result_valid = out_valid_q;
	assign end_index    = end_index_q;
	assign best_start   = best_start_q;
	assign best_cost    = best_cost_q;

	assert property (@(posedge clk) disable iff (!arst_n) fls_q <= cnt_q)
		else $error("first live start beyond sample count");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CNT_W'(MAX_SAMPLES))
		else $error("sample count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside output state");
	assert property (@(posedge clk) disable iff (!arst_n) !(mul_req.start && div_req.start))
		else $error("both shared units started together");

endmodule

`default_nettype wire
